[hdl/wfpd_pkg.sv]
// Shared types and constants for the wall-following PD steering block.
package wfpd_pkg;

   localparam int DIST_W     = 12;
   localparam int GAIN_W     = 12;
   localparam int SPEED_W    = 8;
   localparam int TICK_W     = 32;
   localparam int ERR_W      = 24;
   localparam int DERIV_W    = 9;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam int DERIV_LIMIT = 160;
   localparam int CORR_LIMIT  = 25;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PRESENCE_LIMIT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WALL_TARGET    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIFF_GAIN      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_LEFT      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_RIGHT     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_FLOOR    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_CEILING  = 3'd7;

   // reset values of the configuration registers
   localparam logic [DIST_W-1:0]  RST_PRESENCE_LIMIT = 12'd320;
   localparam logic [DIST_W-1:0]  RST_WALL_TARGET    = 12'd160;
   localparam logic [GAIN_W-1:0]  RST_PROP_GAIN      = 12'd461;
   localparam logic [GAIN_W-1:0]  RST_DIFF_GAIN      = 12'd77;
   localparam logic [SPEED_W-1:0] RST_BASE_LEFT      = 8'd95;
   localparam logic [SPEED_W-1:0] RST_BASE_RIGHT     = 8'd100;
   localparam logic [SPEED_W-1:0] RST_SPEED_FLOOR    = 8'd70;
   localparam logic [SPEED_W-1:0] RST_SPEED_CEILING  = 8'd150;

   typedef struct packed {
      logic                     stabilize;
      logic [DIST_W-1:0]        left_distance;
      logic [DIST_W-1:0]        right_distance;
      logic signed [TICK_W-1:0] left_ticks;
      logic signed [TICK_W-1:0] right_ticks;
   } req_type;

   typedef struct packed {
      logic [SPEED_W-1:0] left_speed;
      logic [SPEED_W-1:0] right_speed;
   } rsp_type;

endpackage

[hdl/wall_following_pd_steering.sv]
// Wall-following PD steering: error select, PD correction and speed clamp.
// rsp_valid rises once an input transfer has passed the input register, the
// error/derivative register and the result register. Throughput: one item per
// cycle while rsp_stall does not hold the pipe.
// Rate is set by the two-stage datapath; previous_error feeds back within one stage.
// Reset (synchronous, active high) empties the pipe, loads register defaults
// and clears previous_error and the saved encoder counts.
module wall_following_pd_steering #(
   parameter int GAIN_FRAC_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  wfpd_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output wfpd_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_we,
   input  logic [wfpd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [wfpd_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import wfpd_pkg::*;

   // correction fraction bits: Q4.x gain times error, plus 4 more
   localparam int FRAC = GAIN_FRAC_BITS + 4;
   // width of the clamped correction (holds +-25 << FRAC)
   localparam int CW   = FRAC + 6;
   // width of base*one -+ correction
   localparam int SW   = FRAC + 11;
   localparam logic signed [37:0] CORR_MAX = 38'(CORR_LIMIT) << FRAC;
   localparam logic signed [37:0] CORR_MIN = -CORR_MAX;
   localparam logic signed [ERR_W-1:0] ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
   localparam logic signed [ERR_W-1:0] ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};

   // ---------------- configuration registers ----------------
   logic [DIST_W-1:0]  presence_limit_ff, presence_limit_in;
   logic [DIST_W-1:0]  wall_target_ff, wall_target_in;
   logic [GAIN_W-1:0]  prop_gain_ff, prop_gain_in;
   logic [GAIN_W-1:0]  diff_gain_ff, diff_gain_in;
   logic [SPEED_W-1:0] base_left_ff, base_left_in;
   logic [SPEED_W-1:0] base_right_ff, base_right_in;
   logic [SPEED_W-1:0] speed_floor_ff, speed_floor_in;
   logic [SPEED_W-1:0] speed_ceiling_ff, speed_ceiling_in;

   always_comb begin
      presence_limit_in = presence_limit_ff;
      wall_target_in    = wall_target_ff;
      prop_gain_in      = prop_gain_ff;
      diff_gain_in      = diff_gain_ff;
      base_left_in      = base_left_ff;
      base_right_in     = base_right_ff;
      speed_floor_in    = speed_floor_ff;
      speed_ceiling_in  = speed_ceiling_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PRESENCE_LIMIT: presence_limit_in = csr_wdata[DIST_W-1:0];
            CSR_WALL_TARGET:    wall_target_in    = csr_wdata[DIST_W-1:0];
            CSR_PROP_GAIN:      prop_gain_in      = csr_wdata[GAIN_W-1:0];
            CSR_DIFF_GAIN:      diff_gain_in      = csr_wdata[GAIN_W-1:0];
            CSR_BASE_LEFT:      base_left_in      = csr_wdata[SPEED_W-1:0];
            CSR_BASE_RIGHT:     base_right_in     = csr_wdata[SPEED_W-1:0];
            CSR_SPEED_FLOOR:    speed_floor_in    = csr_wdata[SPEED_W-1:0];
            CSR_SPEED_CEILING:  speed_ceiling_in  = csr_wdata[SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         presence_limit_ff <= RST_PRESENCE_LIMIT;
         wall_target_ff    <= RST_WALL_TARGET;
         prop_gain_ff      <= RST_PROP_GAIN;
         diff_gain_ff      <= RST_DIFF_GAIN;
         base_left_ff      <= RST_BASE_LEFT;
         base_right_ff     <= RST_BASE_RIGHT;
         speed_floor_ff    <= RST_SPEED_FLOOR;
         speed_ceiling_ff  <= RST_SPEED_CEILING;
      end else begin
         presence_limit_ff <= presence_limit_in;
         wall_target_ff    <= wall_target_in;
         prop_gain_ff      <= prop_gain_in;
         diff_gain_ff      <= diff_gain_in;
         base_left_ff      <= base_left_in;
         base_right_ff     <= base_right_in;
         speed_floor_ff    <= speed_floor_in;
         speed_ceiling_ff  <= speed_ceiling_in;
      end
   end

   // ---------------- pipeline flow control ----------------
   // Each stage moves when the stage after it is empty or moving, so a new
   // transfer is taken while a finished result still waits on rsp_stall.
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_free, s2_free, s1_free;
   logic s1_adv, s2_adv, req_accept;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign s2_adv     = s2_valid_ff && out_free;
   assign s2_free    = !s2_valid_ff || out_free;
   assign s1_adv     = s1_valid_ff && s2_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_accept = req_valid && s1_free;
   assign req_stall  = !s1_free;

   assign s1_valid_in  = s1_free  ? req_valid   : s1_valid_ff;
   assign s2_valid_in  = s2_free  ? s1_valid_ff : s2_valid_ff;
   assign out_valid_in = out_free ? s2_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // ---------------- stage 1: input register ----------------
   req_type s1_req_ff, s1_req_in;

   assign s1_req_in = req_accept ? req_data : s1_req_ff;

   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
   end

   // ---------------- stage A: error select and derivative ----------------
   logic signed [ERR_W-1:0]  prev_error_ff, prev_error_in;
   logic [TICK_W-1:0]        prev_left_ff, prev_left_in;
   logic [TICK_W-1:0]        prev_right_ff, prev_right_in;

   logic                     lwall, rwall, open_space;
   logic signed [DIST_W:0]   err_wall;
   logic [TICK_W-1:0]        delta_l, delta_r;
   logic signed [TICK_W:0]   delta_diff;
   logic signed [ERR_W-1:0]  err_enc, err_sel;
   logic signed [ERR_W:0]    deriv_full;
   logic signed [DERIV_W-1:0] deriv_sel;

   assign lwall      = s1_req_ff.left_distance < presence_limit_ff;
   assign rwall      = s1_req_ff.right_distance < presence_limit_ff;
   assign open_space = !lwall && !rwall;

   always_comb begin
      if (lwall && rwall) begin
         err_wall = $signed({1'b0, s1_req_ff.left_distance})
                  - $signed({1'b0, s1_req_ff.right_distance});
      end else if (lwall) begin
         err_wall = $signed({1'b0, s1_req_ff.left_distance})
                  - $signed({1'b0, wall_target_ff});
      end else begin
         err_wall = $signed({1'b0, wall_target_ff})
                  - $signed({1'b0, s1_req_ff.right_distance});
      end
   end

   // encoder deltas wrap modulo 2^32 and are read as signed
   assign delta_l    = s1_req_ff.left_ticks - prev_left_ff;
   assign delta_r    = s1_req_ff.right_ticks - prev_right_ff;
   assign delta_diff = $signed({delta_l[TICK_W-1], delta_l})
                     - $signed({delta_r[TICK_W-1], delta_r});

   // error = diff * 8 in 1/16 cm, saturated to 24 bits
   always_comb begin
      if (delta_diff[TICK_W:ERR_W-4] == '0 || delta_diff[TICK_W:ERR_W-4] == '1) begin
         err_enc = {delta_diff[ERR_W-4:0], 3'b000};
      end else if (delta_diff[TICK_W]) begin
         err_enc = ERR_MIN;
      end else begin
         err_enc = ERR_MAX;
      end
   end

   assign err_sel = open_space ? err_enc
                  : {{(ERR_W-DIST_W-1){err_wall[DIST_W]}}, err_wall};

   // derivative is dropped when its magnitude goes above 10 cm
   assign deriv_full = $signed({err_sel[ERR_W-1], err_sel})
                     - $signed({prev_error_ff[ERR_W-1], prev_error_ff});
   assign deriv_sel  = (deriv_full > DERIV_LIMIT || deriv_full < -DERIV_LIMIT)
                     ? '0 : deriv_full[DERIV_W-1:0];

   assign prev_error_in = (s1_adv && s1_req_ff.stabilize) ? err_sel : prev_error_ff;
   assign prev_left_in  = (s1_adv && s1_req_ff.stabilize && open_space)
                        ? s1_req_ff.left_ticks : prev_left_ff;
   assign prev_right_in = (s1_adv && s1_req_ff.stabilize && open_space)
                        ? s1_req_ff.right_ticks : prev_right_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff <= '0;
         prev_left_ff  <= '0;
         prev_right_ff <= '0;
      end else begin
         prev_error_ff <= prev_error_in;
         prev_left_ff  <= prev_left_in;
         prev_right_ff <= prev_right_in;
      end
   end

   // ---------------- stage 2 register ----------------
   logic                      s2_stab_ff, s2_stab_in;
   logic signed [ERR_W-1:0]   s2_err_ff, s2_err_in;
   logic signed [DERIV_W-1:0] s2_deriv_ff, s2_deriv_in;

   assign s2_stab_in  = s1_adv ? s1_req_ff.stabilize : s2_stab_ff;
   assign s2_err_in   = s1_adv ? err_sel : s2_err_ff;
   assign s2_deriv_in = s1_adv ? deriv_sel : s2_deriv_ff;

   always_ff @(posedge clock) begin
      s2_stab_ff  <= s2_stab_in;
      s2_err_ff   <= s2_err_in;
      s2_deriv_ff <= s2_deriv_in;
   end

   // ---------------- stage B: PD correction and speed band ----------------
   function automatic logic signed [10:0] trunc_zero(input logic signed [SW-1:0] v);
      logic signed [10:0] q;
      logic               frac_nz;
      q       = v[SW-1:FRAC];
      frac_nz = |v[FRAC-1:0];
      if (v[SW-1] && frac_nz) begin
         q = q + 11'sd1;
      end
      return q;
   endfunction

   // when the band is empty, values below the floor take the floor, all others the ceiling
   function automatic logic [SPEED_W-1:0] band(input logic signed [10:0] v,
                                               input logic [SPEED_W-1:0] lo,
                                               input logic [SPEED_W-1:0] hi);
      logic [SPEED_W-1:0] r;
      if (v < $signed({3'b000, lo})) begin
         r = lo;
      end else if (v > $signed({3'b000, hi})) begin
         r = hi;
      end else begin
         r = v[SPEED_W-1:0];
      end
      return r;
   endfunction

   logic signed [36:0]   prop_term;
   logic signed [21:0]   diff_term;
   logic signed [37:0]   corr_sum, corr_sat;
   logic signed [CW-1:0] corr;
   logic signed [SW-1:0] corr_ext, lscaled, rscaled;
   logic [SW-1:0]        base_l_scaled, base_r_scaled;
   logic signed [10:0]   lraw, rraw;
   rsp_type              rsp_next;

   assign prop_term = $signed({1'b0, prop_gain_ff}) * s2_err_ff;
   assign diff_term = $signed({1'b0, diff_gain_ff}) * s2_deriv_ff;
   assign corr_sum  = $signed({prop_term[36], prop_term})
                    + $signed({{16{diff_term[21]}}, diff_term});

   always_comb begin
      if (corr_sum > CORR_MAX) begin
         corr_sat = CORR_MAX;
      end else if (corr_sum < CORR_MIN) begin
         corr_sat = CORR_MIN;
      end else begin
         corr_sat = corr_sum;
      end
   end

   assign corr          = corr_sat[CW-1:0];
   assign corr_ext      = {{(SW-CW){corr[CW-1]}}, corr};
   assign base_l_scaled = {{(SW-SPEED_W-FRAC){1'b0}}, base_left_ff, {FRAC{1'b0}}};
   assign base_r_scaled = {{(SW-SPEED_W-FRAC){1'b0}}, base_right_ff, {FRAC{1'b0}}};
   assign lscaled       = $signed(base_l_scaled) - corr_ext;
   assign rscaled       = $signed(base_r_scaled) + corr_ext;
   assign lraw          = trunc_zero(lscaled);
   assign rraw          = trunc_zero(rscaled);

   always_comb begin
      if (s2_stab_ff) begin
         rsp_next.left_speed  = band(lraw, speed_floor_ff, speed_ceiling_ff);
         rsp_next.right_speed = band(rraw, speed_floor_ff, speed_ceiling_ff);
      end else begin
         rsp_next.left_speed  = base_left_ff;
         rsp_next.right_speed = base_right_ff;
      end
   end

   // ---------------- result register ----------------
   rsp_type rsp_data_ff, rsp_data_in;

   assign rsp_data_in = s2_adv ? rsp_next : rsp_data_ff;

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // pass-through items leave with the base speeds
   a_pass_through: assert property (@(posedge clock) disable iff (reset)
      s2_adv && !s2_stab_ff |=>
         rsp_data.left_speed == base_left_ff && rsp_data.right_speed == base_right_ff)
      else $error("pass-through speeds differ from base speeds");

   // corrected speeds stay in a non-empty band
   a_in_band: assert property (@(posedge clock) disable iff (reset)
      s2_adv && s2_stab_ff && speed_floor_ff <= speed_ceiling_ff |=>
         rsp_data.left_speed >= speed_floor_ff && rsp_data.left_speed <= speed_ceiling_ff &&
         rsp_data.right_speed >= speed_floor_ff && rsp_data.right_speed <= speed_ceiling_ff)
      else $error("corrected speed outside band");

   // registered derivative never exceeds the limit
   a_deriv_limit: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> s2_deriv_ff <= DERIV_LIMIT && s2_deriv_ff >= -DERIV_LIMIT)
      else $error("derivative beyond limit");

   // saved encoder counts move only on open-space stabilize transfers
   a_counts_hold: assert property (@(posedge clock) disable iff (reset)
      !(s1_adv && s1_req_ff.stabilize && open_space) |=>
         $stable(prev_left_ff) && $stable(prev_right_ff))
      else $error("encoder counts changed outside open space");
`endif

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the wall-following PD steering block.
`timescale 1ns / 1ps

module testbench;
   import wfpd_pkg::*;

   localparam int GAIN_FRAC = 8;
   localparam int FRAC      = GAIN_FRAC + 4;       // fraction bits of the correction
   localparam longint ERR_TOP    = (64'sd1 <<< (ERR_W - 1)) - 1;
   localparam longint ERR_BOTTOM = -(64'sd1 <<< (ERR_W - 1));
   localparam int NUM_PHASES = 8;
   localparam int PHASE_ITEMS = 194;               // random samples per register setting
   localparam int MAX_REPORTS = 10;

   // shadow of the configuration registers
   typedef struct packed {
      logic [DIST_W-1:0]  presence_limit;
      logic [DIST_W-1:0]  wall_target;
      logic [GAIN_W-1:0]  prop_gain;
      logic [GAIN_W-1:0]  diff_gain;
      logic [SPEED_W-1:0] base_left;
      logic [SPEED_W-1:0] base_right;
      logic [SPEED_W-1:0] speed_floor;
      logic [SPEED_W-1:0] speed_ceiling;
   } steer_cfg_type;

   // one directed sample: pinned rows carry speeds read straight off the spec
   typedef struct packed {
      req_type item;
      logic    pinned;
      rsp_type want;
   } directed_row_type;

   localparam steer_cfg_type RESET_SETTINGS = '{
      RST_PRESENCE_LIMIT, RST_WALL_TARGET, RST_PROP_GAIN, RST_DIFF_GAIN,
      RST_BASE_LEFT, RST_BASE_RIGHT, RST_SPEED_FLOOR, RST_SPEED_CEILING};

   // stab, left_dist, right_dist, left_ticks, right_ticks, pinned, left_spd, right_spd
   localparam directed_row_type DIRECTED [17] = '{
      // bypass straight out of reset
      {1'b0, 12'd0,    12'd0,    32'h00000000, 32'h00000000, 1'b1, 8'd95,  8'd100},
      {1'b0, 12'hFFF,  12'hFFF,  32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 8'd95,  8'd100},
      // both walls, large error: correction pinned at the limits
      {1'b1, 12'd0,    12'd319,  32'h00000000, 32'h00000000, 1'b1, 8'd120, 8'd75},
      {1'b1, 12'd319,  12'd0,    32'h00000000, 32'h00000000, 1'b1, 8'd70,  8'd125},
      // left wall on target, derivative jump dropped
      {1'b1, 12'd160,  12'd4095, 32'h00000000, 32'h00000000, 1'b1, 8'd95,  8'd100},
      // right wall only, small error
      {1'b1, 12'd4095, 12'd150,  32'h00000000, 32'h00000000, 1'b0, 8'd0,   8'd0},
      // distance equal to the threshold counts as open space
      {1'b1, 12'd320,  12'd320,  32'h00000000, 32'h00000000, 1'b0, 8'd0,   8'd0},
      // encoder error saturating high, then a wrapped delta, then saturating low
      {1'b1, 12'd4000, 12'd320,  32'h7FFFFFFF, 32'h80000000, 1'b1, 8'd70,  8'd125},
      {1'b1, 12'd320,  12'd4095, 32'h80000000, 32'h7FFFFFFF, 1'b0, 8'd0,   8'd0},
      {1'b1, 12'd4095, 12'd4095, 32'h00000000, 32'hFFFFFFFE, 1'b1, 8'd120, 8'd75},
      // bypass in the middle leaves the state alone
      {1'b0, 12'hAAA,  12'h555,  32'h12345678, 32'hEDCBA987, 1'b1, 8'd95,  8'd100},
      // derivative right at and just past the limit
      {1'b1, 12'd100,  12'd100,  32'h00000000, 32'h00000000, 1'b0, 8'd0,   8'd0},
      {1'b1, 12'd160,  12'd0,    32'h00000000, 32'h00000000, 1'b0, 8'd0,   8'd0},
      {1'b1, 12'd0,    12'd1,    32'h00000000, 32'h00000000, 1'b0, 8'd0,   8'd0},
      {1'b1, 12'd0,    12'd161,  32'h00000000, 32'h00000000, 1'b0, 8'd0,   8'd0},
      // single walls touching the sensor
      {1'b1, 12'd0,    12'd4095, 32'h00000000, 32'h00000000, 1'b0, 8'd0,   8'd0},
      {1'b1, 12'd4095, 12'd0,    32'h00000000, 32'h00000000, 1'b0, 8'd0,   8'd0}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   wall_following_pd_steering #(.GAIN_FRAC_BITS(GAIN_FRAC)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state, mirrors the block after reset
   steer_cfg_type            cfg = RESET_SETTINGS;
   logic signed [ERR_W-1:0]  err_last = '0;
   logic signed [TICK_W-1:0] enc_left_last = '0;
   logic signed [TICK_W-1:0] enc_right_last = '0;

   rsp_type speeds_due [$];       // expected speed pairs, oldest first
   int      mismatches = 0;
   int      speeds_checked = 0;
   int      samples_sent = 0;
   bit      calm = 1'b0;          // no idling on either side while set
   int      hold_left = 0;        // receiver hold-off cycles still to go

   // stimulus generator state
   logic [DIST_W-1:0]        last_left_dist = 12'd160;
   logic [DIST_W-1:0]        last_right_dist = 12'd160;
   logic signed [TICK_W-1:0] left_odo = '0;
   logic signed [TICK_W-1:0] right_odo = '0;

   // Truncate the fraction bits toward zero.
   function automatic longint toward_zero(input longint v);
      if (v >= 0) return v >>> FRAC;
      return -((-v) >>> FRAC);
   endfunction

   // Speed band; with floor above ceiling the floor wins below it.
   function automatic logic [SPEED_W-1:0] clip_band(input longint v);
      longint lo, hi;
      lo = cfg.speed_floor;
      hi = cfg.speed_ceiling;
      if (v < lo) return cfg.speed_floor;
      if (v > hi) return cfg.speed_ceiling;
      return v[SPEED_W-1:0];
   endfunction

   // Motor speeds for one accepted sample; advances the predictor state.
   function automatic rsp_type steer_predict(input req_type r);
      longint ld, rd, target, err, deriv, corr, lim, kp, kd, bl, br, pe;
      logic signed [TICK_W-1:0] dl, dr;
      logic lwall, rwall;
      rsp_type s;
      if (!r.stabilize) begin
         s.left_speed = cfg.base_left;
         s.right_speed = cfg.base_right;
         return s;
      end
      ld = r.left_distance;
      rd = r.right_distance;
      target = cfg.wall_target;
      lwall = r.left_distance < cfg.presence_limit;
      rwall = r.right_distance < cfg.presence_limit;
      if (lwall && rwall) begin
         err = ld - rd;
      end else if (lwall) begin
         err = ld - target;
      end else if (rwall) begin
         err = target - rd;
      end else begin
         // open space: steer on encoder deltas, counts wrap modulo 2^32
         dl = r.left_ticks - enc_left_last;
         dr = r.right_ticks - enc_right_last;
         enc_left_last = r.left_ticks;
         enc_right_last = r.right_ticks;
         err = (longint'(dl) - longint'(dr)) * 8;
      end
      if (err > ERR_TOP) err = ERR_TOP;
      else if (err < ERR_BOTTOM) err = ERR_BOTTOM;
      pe = err_last;
      deriv = err - pe;
      if (deriv > DERIV_LIMIT || deriv < -DERIV_LIMIT) deriv = 0;
      kp = cfg.prop_gain;
      kd = cfg.diff_gain;
      lim = longint'(CORR_LIMIT) <<< FRAC;
      corr = kp * err + kd * deriv;
      if (corr > lim) corr = lim;
      else if (corr < -lim) corr = -lim;
      bl = cfg.base_left;
      br = cfg.base_right;
      s.left_speed = clip_band(toward_zero((bl <<< FRAC) - corr));
      s.right_speed = clip_band(toward_zero((br <<< FRAC) + corr));
      err_last = err[ERR_W-1:0];
      return s;
   endfunction

   // Distance on the wall side (below threshold) or the open side.
   function automatic logic [DIST_W-1:0] side_distance(input logic wall);
      if (wall && cfg.presence_limit != 0)
         return DIST_W'($urandom_range(0, cfg.presence_limit - 1));
      if (wall)
         return DIST_W'($urandom_range(0, (1 << DIST_W) - 1));
      return DIST_W'($urandom_range(cfg.presence_limit, (1 << DIST_W) - 1));
   endfunction

   // Small move of a filtered distance, keeps the derivative in range.
   function automatic logic [DIST_W-1:0] drift(input logic [DIST_W-1:0] d);
      int v;
      v = d;
      v = v + int'($urandom_range(0, 24)) - 12;
      if (v < 0) v = 0;
      if (v > (1 << DIST_W) - 1) v = (1 << DIST_W) - 1;
      return v[DIST_W-1:0];
   endfunction

   // Mostly plausible robot samples: walls either side, open space with
   // encoders creeping forward, plus some fully random noise.
   function automatic req_type next_sample();
      req_type r;
      int kind;
      kind = $urandom_range(0, 9);
      r.stabilize = ($urandom_range(0, 99) < 85);
      left_odo = left_odo + TICK_W'($urandom_range(0, 40)) - TICK_W'(12);
      right_odo = right_odo + TICK_W'($urandom_range(0, 40)) - TICK_W'(12);
      if (kind >= 8) begin
         left_odo = $urandom;
         right_odo = $urandom;
      end
      r.left_ticks = left_odo;
      r.right_ticks = right_odo;
      if (kind < 8 && $urandom_range(0, 1) == 1) begin
         r.left_distance = drift(last_left_dist);
         r.right_distance = drift(last_right_dist);
      end else begin
         case (kind)
            0, 1, 2: begin
               r.left_distance = side_distance(1'b1);
               r.right_distance = side_distance(1'b1);
            end
            3: begin
               r.left_distance = side_distance(1'b1);
               r.right_distance = side_distance(1'b0);
            end
            4: begin
               r.left_distance = side_distance(1'b0);
               r.right_distance = side_distance(1'b1);
            end
            5, 6, 7: begin
               r.left_distance = side_distance(1'b0);
               r.right_distance = side_distance(1'b0);
            end
            default: begin
               r.left_distance = DIST_W'($urandom);
               r.right_distance = DIST_W'($urandom);
            end
         endcase
      end
      last_left_dist = r.left_distance;
      last_right_dist = r.right_distance;
      return r;
   endfunction

   // Register settings per phase: reset values, both extremes, an empty
   // speed band, then random ones.
   function automatic steer_cfg_type phase_settings(input int ph);
      steer_cfg_type s;
      case (ph)
         0: s = RESET_SETTINGS;
         1: s = '{12'd0, 12'd0, 12'd4095, 12'd4095, 8'd0, 8'd0, 8'd0, 8'd255};
         2: s = '{12'd4095, 12'd4095, 12'd0, 12'd0, 8'd255, 8'd255, 8'd255, 8'd255};
         3: s = '{12'd320, 12'd160, 12'd461, 12'd77, 8'd95, 8'd100, 8'd120, 8'd80};
         default: begin
            s.presence_limit = DIST_W'($urandom_range(0, 4095));
            s.wall_target = DIST_W'($urandom_range(0, 4095));
            s.prop_gain = GAIN_W'($urandom_range(0, 4095) >> $urandom_range(0, 5));
            s.diff_gain = GAIN_W'($urandom_range(0, 4095) >> $urandom_range(0, 5));
            s.base_left = SPEED_W'($urandom_range(0, 255));
            s.base_right = SPEED_W'($urandom_range(0, 255));
            s.speed_floor = SPEED_W'($urandom_range(0, 255));
            s.speed_ceiling = SPEED_W'($urandom_range(0, 255));
         end
      endcase
      return s;
   endfunction

   // One register write; csr_we stays up between back-to-back writes.
   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx,
                          input logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   // Write all eight registers; junk in the upper bits of the 8-bit ones.
   task automatic load_settings(input steer_cfg_type s);
      csr_put(CSR_PRESENCE_LIMIT, s.presence_limit);
      csr_put(CSR_WALL_TARGET, s.wall_target);
      csr_put(CSR_PROP_GAIN, s.prop_gain);
      csr_put(CSR_DIFF_GAIN, s.diff_gain);
      csr_put(CSR_BASE_LEFT, {4'($urandom), s.base_left});
      csr_put(CSR_BASE_RIGHT, {4'($urandom), s.base_right});
      csr_put(CSR_SPEED_FLOOR, {4'($urandom), s.speed_floor});
      csr_put(CSR_SPEED_CEILING, {4'($urandom), s.speed_ceiling});
      csr_we <= 1'b0;
      cfg = s;
   endtask

   // Offer one sample, hold it until the transfer, then queue its speeds.
   task automatic offer(input req_type item, input logic pinned, input rsp_type want);
      rsp_type calc;
      while (!calm && $urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      calc = steer_predict(item);
      speeds_due.push_back(pinned ? want : calc);
      samples_sent++;
   endtask

   // Sender goes quiet until every queued result is back, then lets the
   // pipe settle (three stages) before anything else happens.
   task automatic drain();
      req_valid <= 1'b0;
      while (speeds_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic flag(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
   endtask

   // Result checker: values seen here are those present before the edge.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (speeds_due.size() == 0) begin
            flag($sformatf("unexpected transfer left=%0d right=%0d",
                           rsp_data.left_speed, rsp_data.right_speed));
         end else begin
            want = speeds_due.pop_front();
            speeds_checked++;
            if (rsp_data.left_speed !== want.left_speed ||
                rsp_data.right_speed !== want.right_speed)
               flag($sformatf("speed mismatch: expected left=%0d right=%0d, got left=%0d right=%0d",
                              want.left_speed, want.right_speed,
                              rsp_data.left_speed, rsp_data.right_speed));
         end
      end
   end

   // Receiver: random stalls, a counted hold-off on request, none when calm.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 34);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed samples at reset settings
      foreach (DIRECTED[i])
         offer(DIRECTED[i].item, DIRECTED[i].pinned, DIRECTED[i].want);
      drain();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         load_settings(phase_settings(ph));
         calm = (ph == 3);
         for (int j = 0; j < PHASE_ITEMS; j++) begin
            // long receiver hold-off mid phase: pipe fills, input stalls
            if (ph == 4 && j == 40) hold_left = 90;
            offer(next_sample(), 1'b0, '0);
         end
         calm = 1'b0;
         drain();
      end

      $display("Ran %0d steering samples over %0d register settings (extremes, empty band).",
               samples_sent, NUM_PHASES + 1);
      $display("Checked %0d speed pairs, %0d mismatches.", speeds_checked, mismatches);
      if (mismatches == 0 && speeds_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

[files.f]
hdl/wfpd_pkg.sv
hdl/wall_following_pd_steering.sv
tb/sv/testbench.sv
